FILE: src/fut_pkg.sv
package fut_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW = $clog2(MaxResults + 1);
  localparam int unsigned IdxW = $clog2(MaxResults);

  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } fut_kind_e;

  typedef struct packed {
    logic [7:0] data;
    fut_kind_e  kind;
  } fut_res_t;

  typedef struct packed {
    fut_res_t [MaxResults-1:0] res;
    logic [CntW-1:0]           cnt;
  } fut_grp_t;

  typedef struct packed {
    logic full;
    logic push;
  } fut_qctl_t;

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] fut_hex(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic fut_grp_t fut_push(input fut_grp_t g, input logic [7:0] data,
                                        input fut_kind_e kind);
    fut_grp_t r;
    r = g;
    if (g.cnt < CntW'(MaxResults)) begin
      r.res[g.cnt[IdxW-1:0]].data = data;
      r.res[g.cnt[IdxW-1:0]].kind = kind;
      r.cnt = g.cnt + CntW'(1);
    end
    return r;
  endfunction

  // Emits a held escape literally: the percent sign and then any held digit.
  function automatic fut_grp_t fut_flush(input fut_grp_t g, input logic [1:0] esc,
                                         input logic [7:0] held, input fut_kind_e kind);
    fut_grp_t r;
    r = g;
    if (esc >= 2'd1) begin
      r = fut_push(r, CharPct, kind);
    end
    if (esc >= 2'd2) begin
      r = fut_push(r, held, kind);
    end
    return r;
  endfunction

endpackage

FILE: src/fut_in_if.sv
interface fut_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_body;

  modport source (output valid, output in_byte, output end_of_body, input ready);
  modport sink (input valid, input in_byte, input end_of_body, output ready);
endinterface

FILE: src/fut_out_if.sv
interface fut_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] token_kind;
  logic       last;

  modport source (output valid, output out_byte, output token_kind, output last,
                  input ready);
  modport sink (input valid, input out_byte, input token_kind, input last,
                output ready);
endinterface

FILE: src/fut_core.sv
module fut_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             eob_i,
  output fut_pkg::fut_grp_t grp_o
);
  import fut_pkg::*;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DROP  = 2'd3
  } phase_e;

  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscPct   = 2'd1;
  localparam logic [1:0] EscDigit = 2'd2;

  phase_e     phase_q, phase_d;
  logic [1:0] esc_q, esc_d;
  logic [7:0] held_q, held_d;

  always_comb begin
    fut_grp_t   g;
    fut_kind_e  kind;
    logic       do_dec;
    logic       do_flush;
    logic       do_end;
    logic       plain;
    logic [4:0] hc;
    logic [4:0] hh;

    g        = '0;
    kind     = KIND_NAME;
    do_dec   = 1'b0;
    do_flush = 1'b0;
    do_end   = 1'b0;
    plain    = 1'b0;
    phase_d  = phase_q;
    esc_d    = esc_q;
    held_d   = held_q;
    hc       = fut_hex(in_byte_i);
    hh       = fut_hex(held_q);

    case (phase_q)
      PH_START: begin
        if (in_byte_i == CharEq) begin
          phase_d = PH_DROP;
        end else if (in_byte_i != CharAmp) begin
          phase_d = PH_NAME;
          do_dec  = 1'b1;
        end
      end
      PH_NAME: begin
        if (in_byte_i == CharAmp) begin
          do_flush = 1'b1;
          do_end   = 1'b1;
          phase_d  = PH_START;
        end else if (in_byte_i == CharEq) begin
          do_flush = 1'b1;
          phase_d  = PH_VALUE;
        end else begin
          do_dec = 1'b1;
        end
      end
      PH_VALUE: begin
        kind = KIND_VALUE;
        if (in_byte_i == CharAmp) begin
          do_flush = 1'b1;
          do_end   = 1'b1;
          phase_d  = PH_START;
        end else begin
          do_dec = 1'b1;
        end
      end
      default: begin
        esc_d  = EscNone;
        held_d = '0;
        if (in_byte_i == CharAmp) begin
          phase_d = PH_START;
        end
      end
    endcase

    if (do_flush) begin
      g      = fut_flush(g, esc_q, held_q, kind);
      esc_d  = EscNone;
      held_d = '0;
    end
    if (do_end) begin
      g = fut_push(g, 8'h00, KIND_END);
    end

    if (do_dec) begin
      if (esc_q == EscPct) begin
        if (hc[4]) begin
          held_d = in_byte_i;
          esc_d  = EscDigit;
        end else begin
          g      = fut_flush(g, esc_q, held_q, kind);
          esc_d  = EscNone;
          held_d = '0;
          plain  = 1'b1;
        end
      end else if (esc_q == EscDigit) begin
        if (hc[4]) begin
          g      = fut_push(g, {hh[3:0], hc[3:0]}, kind);
          esc_d  = EscNone;
          held_d = '0;
        end else begin
          g      = fut_flush(g, esc_q, held_q, kind);
          esc_d  = EscNone;
          held_d = '0;
          plain  = 1'b1;
        end
      end else begin
        plain = 1'b1;
      end
      if (plain) begin
        if (in_byte_i == CharPct) begin
          esc_d = EscPct;
        end else if (in_byte_i == CharPlus) begin
          g = fut_push(g, CharSpace, kind);
        end else begin
          g = fut_push(g, in_byte_i, kind);
        end
      end
    end

    if (eob_i) begin
      if (phase_d == PH_NAME || phase_d == PH_VALUE) begin
        g = fut_flush(g, esc_d, held_d,
                      (phase_d == PH_NAME) ? KIND_NAME : KIND_VALUE);
        g = fut_push(g, 8'h00, KIND_END);
      end
      phase_d = PH_START;
      esc_d   = EscNone;
      held_d  = '0;
    end

    grp_o = g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      esc_q   <= EscNone;
      held_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: src/fut_res_queue.sv
module fut_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fut_pkg::fut_grp_t grp_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output fut_pkg::fut_res_t res_o,
  output logic              last_o
);
  import fut_pkg::*;

  fut_grp_t        grp_q [2];
  logic            rd_q;
  logic            wr_q;
  logic [1:0]      cnt_q;
  logic [IdxW-1:0] idx_q;
  fut_grp_t        head;
  logic            pop_item;
  logic            pop_grp;

  assign head     = grp_q[rd_q];
  assign valid_o  = (cnt_q != 2'd0);
  assign full_o   = (cnt_q == 2'd2);
  assign res_o    = head.res[idx_q];
  assign last_o   = ({1'b0, idx_q} == CntW'(head.cnt - CntW'(1)));
  assign pop_item = valid_o && ready_i;
  assign pop_grp  = pop_item && last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      grp_q[wr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_grp) begin
        rd_q  <= ~rd_q;
        idx_q <= '0;
      end else if (pop_item) begin
        idx_q <= idx_q + IdxW'(1);
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_grp};
    end
  end

endmodule

FILE: src/urlencoded_form_tokenizer.sv
// Streaming x-www-form-urlencoded tokenizer: takes one body byte per item
// and returns the decoded name bytes, value bytes and end-of-pair tokens it
// causes, with last marking the final token of each byte. A byte is decoded
// in the cycle it is accepted and its tokens are registered into a result
// queue that holds the tokens of two bytes and offers them one token per
// cycle while the output is ready, so bytes that yield one token or none
// stream at one byte per cycle. Later bytes are accepted while a byte's
// tokens drain, but input ready drops while the queue holds two bytes.
module urlencoded_form_tokenizer (
  input  logic clk_i,
  input  logic rst_ni,
  fut_in_if.sink    in_i,
  fut_out_if.source out_o
);
  import fut_pkg::*;

  fut_grp_t  grp;
  fut_qctl_t qctl;
  fut_res_t  res;
  logic      accept;

  assign in_i.ready = !qctl.full;
  assign accept     = in_i.valid && in_i.ready;
  assign qctl.push  = accept && (grp.cnt != '0);

  fut_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .eob_i     (in_i.end_of_body),
    .grp_o     (grp)
  );

  fut_res_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qctl.push),
    .grp_i   (grp),
    .full_o  (qctl.full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res),
    .last_o  (out_o.last)
  );

  assign out_o.out_byte   = res.data;
  assign out_o.token_kind = res.kind;

endmodule

FILE: src/fut_checker.sv
module fut_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] token_kind,
  input logic       last
);
  import fut_pkg::*;

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && token_kind == KIND_END |-> out_byte == 8'h00)
    else $error("end-of-pair token carries a nonzero byte");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last |=> out_valid)
    else $error("token group broken before its last token");

  a_full_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with no token pending");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(token_kind)
    && $stable(last))
    else $error("stalled token changed");

endmodule

bind urlencoded_form_tokenizer fut_checker u_fut_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_byte   (out_o.out_byte),
  .token_kind (out_o.token_kind),
  .last       (out_o.last)
);
